[hdl/ntm_pkg.sv]
// ----------------------------------------------------------------------------
// Numeric token masker package
// Shared constants, character classes and the command and status structures
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package ntm_pkg;

   // Byte width of every character that the block handles.
   localparam int CHAR_W = 8;

   // Capacity of the token store, in bytes (1 to 63).
   localparam int MAX_TOKEN = 63;

   // Width of the token length, which must be able to hold MAX_TOKEN itself.
   localparam int LEN_W = $clog2(MAX_TOKEN + 1);

   // Width of a token store address.
   localparam int ADDR_W = (MAX_TOKEN > 1) ? $clog2(MAX_TOKEN) : 1;

   // Reset value of the mask character, an ASCII 'x'.
   localparam logic [CHAR_W-1:0] MASK_RESET = 8'd120;

   // Character codes.
   localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'd0;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
   localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'd32;
   localparam logic [CHAR_W-1:0] CHAR_HYPHEN  = 8'd45;
   localparam logic [CHAR_W-1:0] CHAR_PERIOD  = 8'd46;
   localparam logic [CHAR_W-1:0] CHAR_SLASH   = 8'd47;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'd65;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'd90;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'd97;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'd122;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic store;       // Token byte accepted: append it to the store.
      logic start;       // Delimiter accepted: latch it for the end of the run.
      logic rd_first;    // Read the first stored byte.
      logic rd_next;     // Read the byte after the current one.
      logic load_byte;   // Load the current token byte into the output register.
      logic load_delim;  // Load the delimiter and close the token.
   } ntm_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_delim;    // The incoming byte ends a token.
      logic empty;       // No byte is stored.
      logic last_byte;   // The current byte is the final stored byte.
      logic slot_free;   // The output register can take a new transaction.
   } ntm_sts_type;

   // True for the bytes that end a token.
   function automatic logic is_delim(input logic [CHAR_W-1:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_SLASH) || (c == CHAR_HYPHEN) ||
             (c == CHAR_PERIOD) || (c == CHAR_NUL);
   endfunction

   // True for ASCII letters of either case.
   function automatic logic is_letter(input logic [CHAR_W-1:0] c);
      return ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) ||
             ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z));
   endfunction

endpackage

[hdl/ntm_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read; the read data
// holds its value while no read is requested.
// ----------------------------------------------------------------------------
module ntm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/ntm_datapath.sv]
// ----------------------------------------------------------------------------
// Numeric token masker datapath
// Holds the token store, the token length and flags, the mask register and
// the output register, and acts on the controller's commands.
// ----------------------------------------------------------------------------
module ntm_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  ntm_pkg::ntm_cmd_type       cmd,
   output ntm_pkg::ntm_sts_type       sts,
   input  logic [ntm_pkg::CHAR_W-1:0] req_in_char,
   input  logic                       csr_write,
   input  logic [ntm_pkg::CHAR_W-1:0] csr_mask_char,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [ntm_pkg::CHAR_W-1:0] rsp_out_char,
   output logic                       rsp_last,
   output logic                       rsp_truncated
);

   logic [ntm_pkg::CHAR_W-1:0] mask_ff;
   logic [ntm_pkg::LEN_W-1:0]  length_ff, length_in;
   logic                       letter_ff, letter_in;
   logic                       ovf_ff, ovf_in;
   logic [ntm_pkg::ADDR_W-1:0] cnt_ff, cnt_in;
   logic [ntm_pkg::CHAR_W-1:0] delim_ff, delim_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [ntm_pkg::CHAR_W-1:0] rsp_char_ff, rsp_char_in;
   logic                       rsp_last_ff, rsp_last_in;
   logic                       rsp_trunc_ff, rsp_trunc_in;
   logic                       has_room;
   logic                       wr_en;
   logic                       rd_en;
   logic [ntm_pkg::ADDR_W-1:0] rd_addr;
   logic [ntm_pkg::CHAR_W-1:0] rd_data;

   assign has_room = (length_ff < ntm_pkg::LEN_W'(ntm_pkg::MAX_TOKEN));
   assign wr_en    = cmd.store && has_room;
   assign rd_en    = cmd.rd_first || cmd.rd_next;
   assign rd_addr  = cmd.rd_first ? '0 : (cnt_ff + ntm_pkg::ADDR_W'(1));

   // Token store.
   ntm_ram #(
      .WIDTH (ntm_pkg::CHAR_W),
      .DEPTH (ntm_pkg::MAX_TOKEN)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (length_ff[ntm_pkg::ADDR_W-1:0]),
      .wr_data (req_in_char),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Status towards the controller.
   assign sts.is_delim  = ntm_pkg::is_delim(req_in_char);
   assign sts.empty     = (length_ff == '0);
   assign sts.last_byte = ((ntm_pkg::LEN_W'(cnt_ff) + ntm_pkg::LEN_W'(1)) == length_ff);
   assign sts.slot_free = !rsp_valid_ff || !rsp_stall;

   // Next values of the token state and the output register.
   always_comb begin
      length_in    = length_ff;
      letter_in    = letter_ff;
      ovf_in       = ovf_ff;
      cnt_in       = cnt_ff;
      delim_in     = delim_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_trunc_in = rsp_trunc_ff;

      // A taken transaction empties the output register.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // Append a token byte, or note that one was dropped.
      if (cmd.store) begin
         if (has_room) begin
            length_in = length_ff + ntm_pkg::LEN_W'(1);
            letter_in = letter_ff || ntm_pkg::is_letter(req_in_char);
         end else begin
            ovf_in = 1'b1;
         end
      end

      // The end of line comes out as a newline.
      if (cmd.start) begin
         delim_in = (req_in_char == ntm_pkg::CHAR_NUL) ? ntm_pkg::CHAR_NEWLINE
                                                       : req_in_char;
      end

      if (cmd.rd_first) begin
         cnt_in = '0;
      end else if (cmd.rd_next) begin
         cnt_in = cnt_ff + ntm_pkg::ADDR_W'(1);
      end

      // A token byte passes unchanged only when the token holds a letter.
      if (cmd.load_byte) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = letter_ff ? rd_data : mask_ff;
         rsp_last_in  = 1'b0;
         rsp_trunc_in = ovf_ff;
      end

      // The delimiter closes the run and clears the token.
      if (cmd.load_delim) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = delim_ff;
         rsp_last_in  = 1'b1;
         rsp_trunc_in = ovf_ff;
         length_in    = '0;
         letter_in    = 1'b0;
         ovf_in       = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= ntm_pkg::MASK_RESET;
         length_ff    <= '0;
         letter_ff    <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            mask_ff <= csr_mask_char;
         end
         length_ff    <= length_in;
         letter_ff    <= letter_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      delim_ff     <= delim_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_trunc_ff <= rsp_trunc_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_char  = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_truncated = rsp_trunc_ff;

endmodule

[hdl/ntm_ctrl.sv]
// ----------------------------------------------------------------------------
// Numeric token masker controller
// Takes bytes while idle and, after a delimiter, steps the datapath through
// the replay of the stored token and the closing delimiter.
// ----------------------------------------------------------------------------
module ntm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  ntm_pkg::ntm_sts_type sts,
   output ntm_pkg::ntm_cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STREAM,
      ST_DELIM
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // Commands and next state.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.store    = accept && !sts.is_delim;
            cmd.start    = accept && sts.is_delim;
            cmd.rd_first = accept && sts.is_delim && !sts.empty;
            if (accept && sts.is_delim) begin
               state_in = sts.empty ? ST_DELIM : ST_STREAM;
            end
         end
         ST_STREAM: begin
            if (sts.slot_free) begin
               cmd.load_byte = 1'b1;
               if (sts.last_byte) begin
                  state_in = ST_DELIM;
               end else begin
                  cmd.rd_next = 1'b1;
               end
            end
         end
         ST_DELIM: begin
            if (sts.slot_free) begin
               cmd.load_delim = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hdl/numeric_token_masker_top.sv]
// ----------------------------------------------------------------------------
// Numeric token masker
// Buffers text tokens and replays them at each delimiter, masking every byte
// of a token that holds no letter.
// ----------------------------------------------------------------------------
// A token byte produces no transaction.
// A delimiter after n stored bytes is accepted, then each byte is read from the store
// and passed out in turn, and then the delimiter; an output stall holds the replay.
// After the delimiter is taken, the stream or delimiter state loads the first result.
// Reset clears the token length, the flags and the output register and sets
// the mask character to 'x'; the token store is not cleared.
module numeric_token_masker_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [ntm_pkg::CHAR_W-1:0] req_in_char,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [ntm_pkg::CHAR_W-1:0] rsp_out_char,
   output logic                       rsp_last,
   output logic                       rsp_truncated,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [ntm_pkg::CHAR_W-1:0] csr_mask_char
);

   ntm_pkg::ntm_cmd_type cmd;
   ntm_pkg::ntm_sts_type sts;

   // The mask register takes a write in any cycle.
   assign csr_ready = 1'b1;

   ntm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   ntm_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_in_char   (req_in_char),
      .csr_write     (csr_valid && csr_ready),
      .csr_mask_char (csr_mask_char),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_char  (rsp_out_char),
      .rsp_last      (rsp_last),
      .rsp_truncated (rsp_truncated)
   );

   // The output register is loaded only when it is free.
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_byte || cmd.load_delim) |-> sts.slot_free)
      else $error("output register overwritten while holding a transaction");

   // A byte is never stored while a delimiter starts a replay.
   a_store_start_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(cmd.store && cmd.start))
      else $error("store and start commanded together");

   // Loading the delimiter returns the controller to idle, which frees the input.
   a_delim_frees_input: assert property (@(posedge clock) disable iff (reset)
      cmd.load_delim |=> !req_stall)
      else $error("input still stalled after the delimiter was loaded");

   // A fresh result follows a load command.
   a_load_gives_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_byte || cmd.load_delim) |=> rsp_valid)
      else $error("load command did not present a transaction");

endmodule
